@@ rtl/core/sorted_list_insert_defines.svh @@
// assertion macros shared by the sorted list insert rtl
`ifndef SORTED_LIST_INSERT_DEFINES_SVH
`define SORTED_LIST_INSERT_DEFINES_SVH

// condition holds at every edge outside reset
`define SLI_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sli assertion failed");

// condition in one cycle implies result in the next
`define SLI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sli assertion failed");

`endif

@@ rtl/core/sli_pkg.sv @@
// shared types, codes and defaults for the sorted list insert block
package sli_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ rtl/core/sli_cell.sv @@
// one storage cell of the sorted chain: compare on insert, rotate on dump
module sli_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sli_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_ins_value,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_left_value,
    input  logic                               i_left_valid,
    input  logic                               i_left_gt,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_right_value,
    input  logic                               i_right_valid,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_head_value,
    output logic signed [sli_pkg::VALUE_W-1:0] o_value,
    output logic                               o_valid,
    output logic                               o_gt
);

    logic signed [sli_pkg::VALUE_W-1:0] r_value;
    logic signed [sli_pkg::VALUE_W-1:0] n_value;
    logic                               r_valid;
    logic                               n_valid;
    logic                               w_tail;

    assign o_gt   = !r_valid || (r_value > i_ins_value);
    assign w_tail = r_valid && !i_right_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.insert) begin
            n_valid = r_valid | i_left_valid;
            if (o_gt) begin
                n_value = i_left_gt ? i_left_value : i_ins_value;
            end
        end else if (i_ctrl.shift) begin
            // tail takes the head value so the list is whole after a full pass
            n_value = w_tail ? i_head_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

@@ rtl/core/sorted_list_insert.sv @@
// top level of the sorted list insert block: cell chain, dump sequencer, output register
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// Input channel (i_in_valid/o_in_ready, i_in_data): operation 0 inserts value
// after all stored values less than or equal to it, operation 1 dumps the list.
// Output channel (o_out_valid/i_out_ready, o_out_data): item_value, status, last.
// Insert: every cell compares against the new value in parallel and the chain
// shifts right by one above the insert point; the single status result is
// registered and shows in the cycle after the transfer.
// A full store drops the insert and answers status full.
// Dump: the chain rotates one cell per output transfer, handing cell 0 to the
// output register, so a dump of N entries gives N results and ends with the list
// restored; an empty store gives one empty result. No new input is taken until
// the last dump result has gone into the output register.
// Throughput: one insert per cycle while the receiver keeps up; a dump holds
// the input until its last entry is in the output register.
// When the receiver stalls the output register holds its result and the chain
// waits; a new item is taken in the cycle the pending result is transferred.
// Reset (synchronous, active low) empties the store and the output register.
`include "sorted_list_insert_defines.svh"

module sorted_list_insert #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sli_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sli_pkg::t_out_item o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic signed [sli_pkg::VALUE_W-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]                w_valid;
    logic [CAPACITY-1:0]                w_gt;
    sli_pkg::t_cell_ctrl                w_ctrl;

    logic               r_state;
    logic               n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_remain;
    logic [CNT_W-1:0]   n_remain;
    logic               r_out_valid;
    logic               n_out_valid;
    sli_pkg::t_out_item r_out;
    sli_pkg::t_out_item n_out;

    logic w_load_ok;
    logic w_in_xfer;
    logic w_full;
    logic w_empty;
    logic w_dump_step;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [sli_pkg::VALUE_W-1:0] w_left_value;
            logic                               w_left_valid;
            logic                               w_left_gt;
            logic signed [sli_pkg::VALUE_W-1:0] w_right_value;
            logic                               w_right_valid;
            if (g == 0) begin : g_first
                assign w_left_value = i_in_data.value;
                assign w_left_valid = 1'b1;
                assign w_left_gt    = 1'b0;
            end else begin : g_inner_l
                assign w_left_value = w_value[g-1];
                assign w_left_valid = w_valid[g-1];
                assign w_left_gt    = w_gt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right_value = w_value[0];
                assign w_right_valid = 1'b0;
            end else begin : g_inner_r
                assign w_right_value = w_value[g+1];
                assign w_right_valid = w_valid[g+1];
            end
            sli_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_ins_value   (i_in_data.value),
                .i_left_value  (w_left_value),
                .i_left_valid  (w_left_valid),
                .i_left_gt     (w_left_gt),
                .i_right_value (w_right_value),
                .i_right_valid (w_right_valid),
                .i_head_value  (w_value[0]),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    assign w_load_ok   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_load_ok;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_dump_step = (r_state == ST_DUMP) && w_load_ok;

    assign w_ctrl.insert = w_in_xfer && (i_in_data.operation == sli_pkg::OP_INSERT) && !w_full;
    assign w_ctrl.shift  = (w_in_xfer && (i_in_data.operation == sli_pkg::OP_DUMP) && !w_empty)
                           || w_dump_step;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_out_valid = 1'b1;
                    if (i_in_data.operation == sli_pkg::OP_INSERT) begin
                        n_out.item_value = '0;
                        n_out.last       = 1'b1;
                        if (w_full) begin
                            n_out.status = sli_pkg::ST_FULL;
                        end else begin
                            n_out.status = sli_pkg::ST_INSERTED;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (w_empty) begin
                        n_out.item_value = '0;
                        n_out.status     = sli_pkg::ST_EMPTY;
                        n_out.last       = 1'b1;
                    end else begin
                        n_out.item_value = w_value[0];
                        n_out.status     = sli_pkg::ST_ENTRY;
                        n_out.last       = (r_count == CNT_W'(1));
                        n_remain         = r_count - CNT_W'(1);
                        if (r_count != CNT_W'(1)) begin
                            n_state = ST_DUMP;
                        end
                    end
                end
            end
            ST_DUMP: begin
                if (w_load_ok) begin
                    n_out_valid      = 1'b1;
                    n_out.item_value = w_value[0];
                    n_out.status     = sli_pkg::ST_ENTRY;
                    n_out.last       = (r_remain == CNT_W'(1));
                    n_remain         = r_remain - CNT_W'(1);
                    if (r_remain == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SLI_ASSERT_ALWAYS(a_count_matches_cells, $countones(w_valid) == int'(r_count))
    `SLI_ASSERT_ALWAYS(a_dump_not_empty, (r_state != ST_DUMP) || (r_remain != '0))
    `SLI_ASSERT_NEXT(a_insert_grows, w_ctrl.insert, r_count == $past(r_count) + CNT_W'(1))
    `SLI_ASSERT_ALWAYS(a_no_take_in_dump, (r_state != ST_DUMP) || !o_in_ready)

endmodule

@@ tb/sv/tb.sv @@
// testbench for the sorted list insert block: queued stimulus, clocked driver, monitor and checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = sli_pkg::CAPACITY_DEF;
    localparam int N_RANDOM = 400;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sli_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        sli_pkg::t_in_item item;
        bit                drain;
    } t_pending;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    sli_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sli_pkg::t_out_item out_data;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;

    t_pending                           pending_items[$];
    sli_pkg::t_out_item                 expected_results[$];
    logic signed [sli_pkg::VALUE_W-1:0] stored_values[$];
    logic signed [sli_pkg::VALUE_W-1:0] sent_values[$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    sorted_list_insert #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic add_item(input logic op, input logic signed [sli_pkg::VALUE_W-1:0] v,
                            input bit d);
        t_pending p;
        p.item.operation = op;
        p.item.value = v;
        p.drain = d;
        pending_items.push_back(p);
        if (op == sli_pkg::OP_INSERT) begin
            sent_values.push_back(v);
        end
    endtask

    function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
        logic signed [sli_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 16)) - 8;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                if (sent_values.size() > 0) begin
                    v = sent_values[$urandom_range(0, sent_values.size() - 1)];
                end else begin
                    v = $urandom;
                end
            end
        endcase
        return v;
    endfunction

    task automatic predict_transfer(input sli_pkg::t_in_item item);
        int                 pos;
        sli_pkg::t_out_item res;
        res = '0;
        res.last = 1'b1;
        if (item.operation == sli_pkg::OP_INSERT) begin
            if (stored_values.size() >= LIST_DEPTH) begin
                res.status = sli_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < stored_values.size() &&
                       stored_values[pos] <= $signed(item.value)) begin
                    pos++;
                end
                stored_values.insert(pos, item.value);
                res.status = sli_pkg::ST_INSERTED;
            end
            expected_results.push_back(res);
        end else if (stored_values.size() == 0) begin
            res.status = sli_pkg::ST_EMPTY;
            expected_results.push_back(res);
        end else begin
            foreach (stored_values[i]) begin
                res.item_value = stored_values[i];
                res.status = sli_pkg::ST_ENTRY;
                res.last = (i == stored_values.size() - 1);
                expected_results.push_back(res);
            end
        end
    endtask

    task automatic check_result(input sli_pkg::t_out_item got);
        sli_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: item_value %0d status %0d last %0d",
                   got.item_value, got.status, got.last);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.item_value !== want.item_value) begin
                $error("item_value expected %0d got %0d", want.item_value, got.item_value);
                error_count++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d got %0d", want.last, got.last);
                error_count++;
            end
        end
    endtask

    // input driver
    always @(negedge clk) begin
        logic     next_valid;
        t_pending next;
        next_valid = in_valid;
        if (rst_n) begin
            if (in_valid && in_fire) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_results.size() > 0)) begin
                    next = pending_items.pop_front();
                    in_data <= next.item;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 31) == 0) begin
                        send_calm = !send_calm;
                    end
                    send_gap = send_calm ? 0 : $urandom_range(0, 3);
                end
            end
        end
        in_valid <= next_valid;
    end

    // result receiver
    always @(negedge clk) begin
        logic next_ready;
        next_ready = out_ready;
        if (rst_n) begin
            if (out_ready && out_fire) begin
                if ($urandom_range(0, 31) == 0) begin
                    recv_calm = !recv_calm;
                end
                recv_stall = recv_calm ? 0 : $urandom_range(0, 3);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        out_ready <= next_ready;
    end

    // monitor
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                check_result(out_data);
            end
            if (in_valid && in_ready) begin
                predict_transfer(in_data);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int   k;
        logic op;

        // empty store, extremes, ties at head, middle and tail
        add_item(sli_pkg::OP_DUMP, 32'sd5, 1'b0);
        add_item(sli_pkg::OP_INSERT, '0, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MAX, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MIN, 1'b0);
        add_item(sli_pkg::OP_DUMP, '1, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MAX, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MIN, 1'b0);
        add_item(sli_pkg::OP_INSERT, '0, 1'b0);
        add_item(sli_pkg::OP_INSERT, -32'sd1, 1'b0);
        add_item(sli_pkg::OP_INSERT, 32'sd1, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MAX - 1, 1'b0);
        add_item(sli_pkg::OP_INSERT, VAL_MIN + 1, 1'b0);
        add_item(sli_pkg::OP_DUMP, VAL_MIN, 1'b0);
        add_item(sli_pkg::OP_INSERT, 32'sh5555_5555, 1'b0);
        add_item(sli_pkg::OP_INSERT, 32'shaaaa_aaaa, 1'b0);
        add_item(sli_pkg::OP_DUMP, VAL_MAX, 1'b0);

        for (k = 0; k < N_RANDOM; k++) begin
            op = ($urandom_range(0, 5) == 0) ? sli_pkg::OP_DUMP : sli_pkg::OP_INSERT;
            add_item(op, pick_value(), (k == 0) || (k == N_RANDOM / 2) ||
                     ($urandom_range(0, 49) == 0));
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (!((pending_items.size() == 0 && !in_valid && expected_results.size() == 0) ||
                 idle_cycles >= STALL_LIMIT)) begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (idle_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", idle_cycles);
            error_count++;
        end
        if (expected_results.size() > 0) begin
            $error("%0d results still outstanding", expected_results.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sorted_list_insert.f @@
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_cell.sv
rtl/core/sorted_list_insert.sv
tb/sv/tb.sv
